[hdl/bfoa_pkg.sv]
package bfoa_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ADDR_W = 32;
  localparam int SIZE_W = ADDR_W + 1;
  localparam int SUM_W = ADDR_W + 2;
  localparam int ALIGN_W = 5;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(8);

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_OVERFLOW   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_UPDATE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic last_read;
  } sts_t;

endpackage

[hdl/bfoa_ctrl.sv]
module bfoa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  bfoa_pkg::sts_t  sts,
  output bfoa_pkg::cmd_t  cmd
);

  bfoa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfoa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      bfoa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = bfoa_pkg::S_SCAN;
        end
      end
      bfoa_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last_read) begin
          state_nxt = bfoa_pkg::S_FLUSH;
        end
      end
      bfoa_pkg::S_FLUSH: begin
        state_nxt = bfoa_pkg::S_UPDATE;
      end
      bfoa_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = bfoa_pkg::S_RESP;
      end
      bfoa_pkg::S_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = bfoa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfoa_pkg::S_IDLE;
    endcase
  end

endmodule

[hdl/bfoa_dpath.sv]
module bfoa_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bfoa_pkg::cmd_t                 cmd,
  output bfoa_pkg::sts_t                 sts,
  input  logic                           in_action,
  input  logic [31:0]                    in_request_size,
  input  logic [31:0]                    in_free_addr,
  input  logic                           cfg_valid,
  input  logic [bfoa_pkg::ALIGN_W-1:0]   cfg_alignment_log2,
  output logic [31:0]                    out_result_offset,
  output logic [31:0]                    out_peak_now,
  output logic [1:0]                     out_status
);

  localparam int AW = bfoa_pkg::ADDR_W;
  localparam int SW = bfoa_pkg::SIZE_W;
  localparam int XW = bfoa_pkg::SUM_W;
  localparam int IW = bfoa_pkg::IDX_W;

  logic [AW-1:0] head_mem [bfoa_pkg::ENTRIES];
  logic [AW-1:0] len_mem  [bfoa_pkg::ENTRIES];

  logic [bfoa_pkg::ALIGN_W-1:0] align_r;
  logic [AW-1:0] peak_r, peak_nxt;
  logic [bfoa_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic act_r;
  logic [SW-1:0] size_r;
  logic [AW-1:0] addr_r;
  logic [IW-1:0] idx_r, rd_idx_r;
  logic rd_vld_r;
  logic [AW-1:0] rd_head_r, rd_len_r;
  logic best_fnd_r, tl_fnd_r, nx_fnd_r, em_fnd_r;
  logic [IW-1:0] best_idx_r, tl_idx_r, nx_idx_r, em_idx_r;
  logic [AW-1:0] best_head_r, best_len_r, tl_head_r, tl_len_r, nx_len_r;
  logic [AW-1:0] res_off_r, res_off_nxt;
  logic [1:0] res_st_r, res_st_nxt;

  logic [SW-1:0] mask, size_rnd;
  logic cur_v;
  logic [SW-1:0] rd_end, tl_target;
  logic [XW-1:0] free_end;
  logic fit, better;

  logic wr_en;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_head, wr_len;

  logic [SW-1:0] grow;
  logic [XW-1:0] peak_grow, peak_size, free_len;
  logic nx_use;
  logic [AW-1:0] fhead;
  logic [IW-1:0] fslot;

  assign sts.last_read = (idx_r == IW'(bfoa_pkg::ENTRIES - 1));

  assign mask = (SW'(1) << align_r) - SW'(1);
  assign size_rnd = ({1'b0, in_request_size} + mask) & ~mask;

  assign cur_v = valid_r[rd_idx_r];
  assign rd_end = {1'b0, rd_head_r} + {1'b0, rd_len_r};
  assign tl_target = (act_r == bfoa_pkg::ACT_FREE) ? {1'b0, addr_r} : {1'b0, peak_r};
  assign free_end = {2'b0, addr_r} + {1'b0, size_r};
  assign fit = ({1'b0, rd_len_r} >= size_r);
  assign better = !best_fnd_r || (rd_len_r < best_len_r) ||
                  ((rd_len_r == best_len_r) && (rd_head_r < best_head_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= bfoa_pkg::ALIGN_RESET;
    end else if (cfg_valid) begin
      align_r <= cfg_alignment_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      size_r <= size_rnd;
      addr_r <= in_free_addr;
    end
    if (cmd.scan) begin
      rd_head_r <= head_mem[idx_r];
      rd_len_r <= len_mem[idx_r];
      rd_idx_r <= idx_r;
    end
    if (wr_en) begin
      head_mem[wr_idx] <= wr_head;
      len_mem[wr_idx] <= wr_len;
    end
    if (cmd.update) begin
      res_off_r <= res_off_nxt;
      res_st_r <= res_st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      rd_vld_r <= 1'b0;
      best_fnd_r <= 1'b0;
      tl_fnd_r <= 1'b0;
      nx_fnd_r <= 1'b0;
      em_fnd_r <= 1'b0;
      peak_r <= '0;
      valid_r <= '0;
    end else begin
      rd_vld_r <= cmd.scan;
      peak_r <= peak_nxt;
      valid_r <= valid_nxt;
      if (cmd.load) begin
        idx_r <= '0;
        best_fnd_r <= 1'b0;
        tl_fnd_r <= 1'b0;
        nx_fnd_r <= 1'b0;
        em_fnd_r <= 1'b0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + IW'(1);
      end
      if (rd_vld_r) begin
        if (cur_v && fit && better) begin
          best_fnd_r <= 1'b1;
          best_idx_r <= rd_idx_r;
          best_head_r <= rd_head_r;
          best_len_r <= rd_len_r;
        end
        if (cur_v && !tl_fnd_r && (rd_end == tl_target)) begin
          tl_fnd_r <= 1'b1;
          tl_idx_r <= rd_idx_r;
          tl_head_r <= rd_head_r;
          tl_len_r <= rd_len_r;
        end
        if (cur_v && !nx_fnd_r && ({2'b0, rd_head_r} == free_end)) begin
          nx_fnd_r <= 1'b1;
          nx_idx_r <= rd_idx_r;
          nx_len_r <= rd_len_r;
        end
        if (!cur_v && !em_fnd_r) begin
          em_fnd_r <= 1'b1;
          em_idx_r <= rd_idx_r;
        end
      end
    end
  end

  assign grow = size_r - {1'b0, tl_len_r};
  assign peak_grow = {2'b0, peak_r} + {1'b0, grow};
  assign peak_size = {2'b0, peak_r} + {1'b0, size_r};
  assign nx_use = nx_fnd_r && !(tl_fnd_r && (tl_idx_r == nx_idx_r));
  assign fhead = tl_fnd_r ? tl_head_r : addr_r;
  assign fslot = tl_fnd_r ? tl_idx_r : (nx_use ? nx_idx_r : em_idx_r);
  assign free_len = {1'b0, size_r} + (tl_fnd_r ? {2'b0, tl_len_r} : '0) +
                    (nx_use ? {2'b0, nx_len_r} : '0);

  always_comb begin
    peak_nxt = peak_r;
    valid_nxt = valid_r;
    res_off_nxt = '0;
    res_st_nxt = bfoa_pkg::ST_OK;
    wr_en = 1'b0;
    wr_idx = best_idx_r;
    wr_head = best_head_r + size_r[AW-1:0];
    wr_len = best_len_r - size_r[AW-1:0];
    if (cmd.update) begin
      if (act_r == bfoa_pkg::ACT_ALLOC) begin
        if (best_fnd_r) begin
          res_off_nxt = best_head_r;
          if ({1'b0, best_len_r} > size_r) begin
            wr_en = 1'b1;
          end else begin
            valid_nxt[best_idx_r] = 1'b0;
          end
        end else if (tl_fnd_r) begin
          if (peak_grow[XW-1:AW] != '0) begin
            res_st_nxt = bfoa_pkg::ST_OVERFLOW;
          end else begin
            valid_nxt[tl_idx_r] = 1'b0;
            peak_nxt = peak_grow[AW-1:0];
            res_off_nxt = tl_head_r;
          end
        end else if (peak_size[XW-1:AW] != '0) begin
          res_st_nxt = bfoa_pkg::ST_OVERFLOW;
        end else begin
          res_off_nxt = peak_r;
          peak_nxt = peak_size[AW-1:0];
        end
      end else begin
        if (free_end[XW-1:AW] != '0) begin
          res_st_nxt = bfoa_pkg::ST_OVERFLOW;
        end else if (!tl_fnd_r && !nx_use && (size_r == '0)) begin
          res_off_nxt = addr_r;
        end else if (!tl_fnd_r && !nx_use && !em_fnd_r) begin
          res_st_nxt = bfoa_pkg::ST_TABLE_FULL;
        end else begin
          if (tl_fnd_r && nx_use) begin
            valid_nxt[nx_idx_r] = 1'b0;
          end
          valid_nxt[fslot] = 1'b1;
          wr_en = 1'b1;
          wr_idx = fslot;
          wr_head = fhead;
          wr_len = free_len[AW-1:0];
          res_off_nxt = fhead;
        end
      end
    end
  end

  assign out_result_offset = res_off_r;
  assign out_peak_now = peak_r;
  assign out_status = res_st_r;

endmodule

[hdl/best_fit_offset_allocator_core.sv]
// Best-fit offset allocator over a 32-entry free table. One request at a time:
// after a request is accepted, every free-table entry is read in turn through
// the table memory's single read port, the last read is evaluated, the table is
// updated; the result is then offered and held until taken. alignment_log2 may
// be written only while no request is in flight.
module best_fit_offset_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [31:0]                    in_request_size,
  input  logic [31:0]                    in_free_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_result_offset,
  output logic [31:0]                    out_peak_now,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfoa_pkg::ALIGN_W-1:0]   cfg_alignment_log2
);

  bfoa_pkg::cmd_t cmd;
  bfoa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bfoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfoa_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_request_size    (in_request_size),
    .in_free_addr       (in_free_addr),
    .cfg_valid          (cfg_valid),
    .cfg_alignment_log2 (cfg_alignment_log2),
    .out_result_offset  (out_result_offset),
    .out_peak_now       (out_peak_now),
    .out_status         (out_status)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam logic [63:0] ARENA_LIMIT = 64'hFFFF_FFFF;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [31:0]        offset;
    logic [31:0]        peak;
    bfoa_pkg::status_t  status;
  } alloc_result_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] size;
  } live_block_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_action;
  logic [31:0]                   in_request_size;
  logic [31:0]                   in_free_addr;
  logic                          out_valid;
  logic                          out_stall;
  logic [31:0]                   out_result_offset;
  logic [31:0]                   out_peak_now;
  logic [1:0]                    out_status;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bfoa_pkg::ALIGN_W-1:0]  cfg_alignment_log2;

  logic [63:0] blk_head [bfoa_pkg::ENTRIES];
  logic [63:0] blk_len [bfoa_pkg::ENTRIES];
  bit          blk_used [bfoa_pkg::ENTRIES];
  logic [63:0] peak_mark;
  logic [4:0]  align_log2;

  alloc_result_t pending_results[$];
  live_block_t   live_blocks[$];
  int errors = 0;
  int send_pct;
  int recv_pct;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int idle_cyc;

  best_fit_offset_allocator_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_request_size    (in_request_size),
    .in_free_addr       (in_free_addr),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_offset  (out_result_offset),
    .out_peak_now       (out_peak_now),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_alignment_log2 (cfg_alignment_log2)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int tail_match(logic [63:0] at);
    for (int i = 0; i < bfoa_pkg::ENTRIES; i++) begin
      if (blk_used[i] && blk_head[i] + blk_len[i] == at) return i;
    end
    return -1;
  endfunction

  function automatic alloc_result_t plan_request(bfoa_pkg::action_t act,
                                                 logic [31:0] raw_size,
                                                 logic [31:0] addr);
    logic [63:0] mask, sz, head, len, grow;
    int best, prev, nxt, slot;
    alloc_result_t r;
    mask = (64'd1 << align_log2) - 64'd1;
    sz = ({32'd0, raw_size} + mask) & ~mask;
    r.offset = '0;
    r.status = bfoa_pkg::ST_OK;
    if (act == bfoa_pkg::ACT_ALLOC) begin
      best = -1;
      for (int i = 0; i < bfoa_pkg::ENTRIES; i++) begin
        if (blk_used[i] && blk_len[i] >= sz &&
            (best < 0 || blk_len[i] < blk_len[best] ||
             (blk_len[i] == blk_len[best] && blk_head[i] < blk_head[best])))
          best = i;
      end
      if (best >= 0) begin
        r.offset = blk_head[best][31:0];
        if (blk_len[best] > sz) begin
          blk_head[best] = blk_head[best] + sz;
          blk_len[best] = blk_len[best] - sz;
        end else begin
          blk_used[best] = 1'b0;
        end
      end else begin
        prev = tail_match(peak_mark);
        if (prev >= 0) begin
          grow = sz - blk_len[prev];
          if (grow > ARENA_LIMIT - peak_mark) begin
            r.status = bfoa_pkg::ST_OVERFLOW;
          end else begin
            blk_used[prev] = 1'b0;
            peak_mark = peak_mark + grow;
            r.offset = blk_head[prev][31:0];
          end
        end else if (sz > ARENA_LIMIT - peak_mark) begin
          r.status = bfoa_pkg::ST_OVERFLOW;
        end else begin
          r.offset = peak_mark[31:0];
          peak_mark = peak_mark + sz;
        end
      end
    end else if (sz > ARENA_LIMIT - {32'd0, addr}) begin
      r.status = bfoa_pkg::ST_OVERFLOW;
    end else begin
      head = {32'd0, addr};
      len = sz;
      prev = tail_match(head);
      nxt = -1;
      for (int i = 0; i < bfoa_pkg::ENTRIES; i++) begin
        if (nxt < 0 && blk_used[i] && blk_head[i] == head + sz) nxt = i;
      end
      if (nxt == prev) nxt = -1;
      slot = -1;
      if (prev < 0 && nxt < 0) begin
        if (len == 0) begin
          r.offset = addr;
          r.peak = peak_mark[31:0];
          return r;
        end
        for (int i = bfoa_pkg::ENTRIES - 1; i >= 0; i--) begin
          if (!blk_used[i]) slot = i;
        end
        if (slot < 0) begin
          r.status = bfoa_pkg::ST_TABLE_FULL;
          r.peak = peak_mark[31:0];
          return r;
        end
      end
      if (prev >= 0) begin
        head = blk_head[prev];
        len = len + blk_len[prev];
        slot = prev;
      end
      if (nxt >= 0) begin
        len = len + blk_len[nxt];
        if (slot < 0) slot = nxt;
        else blk_used[nxt] = 1'b0;
      end
      blk_head[slot] = head;
      blk_len[slot] = len;
      blk_used[slot] = 1'b1;
      r.offset = head[31:0];
    end
    r.peak = peak_mark[31:0];
    return r;
  endfunction

  task automatic send_request(bfoa_pkg::action_t act, logic [31:0] raw_size,
                              logic [31:0] addr, output alloc_result_t r);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_request_size <= raw_size;
    in_free_addr <= addr;
    do @(posedge clk); while (in_stall);
    r = plan_request(act, raw_size, addr);
    pending_results.push_back(r);
  endtask

  task automatic alloc_block(logic [31:0] raw_size);
    alloc_result_t r;
    live_block_t b;
    send_request(bfoa_pkg::ACT_ALLOC, raw_size, $urandom, r);
    if (r.status == bfoa_pkg::ST_OK && raw_size != 0) begin
      b.addr = r.offset;
      b.size = raw_size;
      live_blocks.push_back(b);
    end
  endtask

  task automatic free_live(bit keep);
    alloc_result_t r;
    live_block_t b;
    int k;
    k = $urandom_range(live_blocks.size() - 1);
    b = live_blocks[k];
    if (!keep) live_blocks.delete(k);
    send_request(bfoa_pkg::ACT_FREE, b.size, b.addr, r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alignment(logic [4:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_alignment_log2 <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    align_log2 = value;
  endtask

  task automatic test_table_full();
    alloc_result_t r;
    write_alignment(5'd8);
    live_blocks.delete();
    for (int i = 0; i < 70; i++) send_request(bfoa_pkg::ACT_ALLOC, 32'd200, $urandom, r);
    for (int i = 0; i < 70; i += 2) send_request(bfoa_pkg::ACT_FREE, 32'd256, i * 256, r);
    for (int i = 1; i < 70; i += 2) send_request(bfoa_pkg::ACT_FREE, 32'd256, i * 256, r);
    for (int i = 64; i < 70; i += 2) send_request(bfoa_pkg::ACT_FREE, 32'd256, i * 256, r);
  endtask

  task automatic test_corners();
    alloc_result_t r;
    write_alignment(5'd0);
    send_request(bfoa_pkg::ACT_ALLOC, 32'd0, 32'hFFFF_FFFF, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'd1, 32'd0, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'd0, r);
    send_request(bfoa_pkg::ACT_FREE, 32'd0, 32'h1234_5678, r);
    send_request(bfoa_pkg::ACT_FREE, 32'h100, 32'hFFFF_FFF0, r);
    send_request(bfoa_pkg::ACT_FREE, 32'd1, 32'hFFFF_FFFF, r);
    send_request(bfoa_pkg::ACT_FREE, 32'd3, peak_mark[31:0], r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'd0, 32'd0, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'd2, 32'd0, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'd9, 32'd0, r);
    write_alignment(5'd16);
    send_request(bfoa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'd0, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'd1, 32'd0, r);
    send_request(bfoa_pkg::ACT_FREE, 32'd1, 32'hFFFF_0000, r);
    send_request(bfoa_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'd0, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'h0001_0001, 32'd0, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'h8000_0000, 32'd0, r);
    send_request(bfoa_pkg::ACT_ALLOC, 32'h7FFF_FFFF, 32'd0, r);
  endtask

  task automatic test_holdoff();
    hold_req <= hold_req + 1;
    for (int i = 0; i < 6; i++) alloc_block($urandom_range(1, 300));
    drain_results();
  endtask

  task automatic test_random(int n_items, int s_pct, int r_pct);
    int pick;
    send_pct = s_pct;
    recv_pct = r_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(3))
          0: write_alignment(5'd0);
          1: write_alignment(5'd16);
          default: write_alignment(5'($urandom_range(0, 16)));
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 45 || live_blocks.size() == 0) begin
        alloc_block($urandom_range(1, 1 << $urandom_range(0, 12)));
      end else if (pick < 87) begin
        free_live(1'b0);
      end else if (pick < 91) begin
        free_live(1'b1);
      end else if (pick < 98) begin
        alloc_result_t r;
        send_request(bfoa_pkg::ACT_FREE, $urandom, $urandom, r);
      end else begin
        alloc_block($urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result offset=%h peak=%h status=%0d",
               out_result_offset, out_peak_now, out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_result_offset !== e.offset) begin
          $error("result_offset expected %h actual %h", e.offset, out_result_offset);
          errors++;
        end
        if (out_peak_now !== e.peak) begin
          $error("peak_now expected %h actual %h", e.peak, out_peak_now);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    send_pct = 12;
    recv_pct = 76;
    hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = 1'b0;
    in_request_size = '0;
    in_free_addr = '0;
    cfg_valid = 1'b0;
    cfg_alignment_log2 = '0;
    for (int i = 0; i < bfoa_pkg::ENTRIES; i++) begin
      blk_head[i] = '0;
      blk_len[i] = '0;
      blk_used[i] = 1'b0;
    end
    peak_mark = '0;
    align_log2 = bfoa_pkg::ALIGN_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_full();
    test_corners();
    test_holdoff();
    test_random(450, 12, 76);
    test_random(450, 76, 12);
    test_random(450, 0, 0);
    drain_results();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/bfoa_pkg.sv
hdl/bfoa_ctrl.sv
hdl/bfoa_dpath.sv
hdl/best_fit_offset_allocator_core.sv
sim/tb.sv
